[sv/u8sd_pkg.sv]
// Package with the shared constants, types and helper functions of the UTF-8 stream decoder.
`default_nettype none
package u8sd_pkg;

  localparam int BYTE_W        = 8;
  localparam int CP_W          = 32;
  localparam int LEN_W         = 3;
  localparam int MAX_SEQ_BYTES = 6;
  localparam int PAYLOAD_W     = 6;

  localparam logic [CP_W-1:0]   ALL_ONES     = '1;
  localparam logic [CP_W-1:0]   OVERLONG_MAX = 32'h0000_007F;
  localparam logic [BYTE_W-1:0] CONT_MASK    = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG     = 8'h80;
  localparam logic [BYTE_W-1:0] FULL_MASK    = 8'hFF;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(FIFO_DEPTH - 2);

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            error;
    logic            last;
  } result_t;

  typedef struct packed {
    logic    v0;
    result_t r0;
    logic    v1;
    result_t r1;
  } push_t;

  // Counts the leading ones of a byte, capped at the longest sequence length.
  function automatic logic [LEN_W-1:0] lead_ones(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] n;
    logic             run;
    n   = '0;
    run = 1'b1;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (run && b[i] && (n < LEN_W'(MAX_SEQ_BYTES))) begin
        n = n + LEN_W'(1);
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

[sv/u8sd_byte_if.sv]
// Interface for the byte input channel.
`default_nettype none
interface u8sd_byte_if;
  logic                         valid;
  logic                         ready;
  logic [u8sd_pkg::BYTE_W-1:0]  in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

[sv/u8sd_result_if.sv]
// Interface for the decoded result channel.
`default_nettype none
interface u8sd_result_if;
  logic                       valid;
  logic                       ready;
  logic [u8sd_pkg::CP_W-1:0]  code_point;
  logic                       error;
  logic                       last;

  modport source (output valid, output code_point, output error, output last, input ready);
  modport sink (input valid, input code_point, input error, input last, output ready);
endinterface
`default_nettype wire

[sv/u8sd_in_stage.sv]
// Input register stage that holds one byte until the decoder can take it.
`default_nettype none
module u8sd_in_stage (
  input  wire logic                        clk,
  input  wire logic                        rst,
  u8sd_byte_if.sink                        bytes,
  input  wire logic                        room,
  output logic                             fire,
  output logic [u8sd_pkg::BYTE_W-1:0]      held_byte
);

  logic held_valid;

  assign fire        = held_valid && room;
  assign bytes.ready = !held_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (bytes.ready) begin
      held_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      held_byte <= bytes.in_byte;
    end
  end

endmodule
`default_nettype wire

[sv/u8sd_decoder.sv]
// Decoder step: sequence state registers and the logic that turns one byte into results.
`default_nettype none
module u8sd_decoder (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        fire,
  input  wire logic [u8sd_pkg::BYTE_W-1:0] held_byte,
  input  wire logic                        decode_enable,
  output u8sd_pkg::push_t                  push
);

  logic [u8sd_pkg::LEN_W-1:0] bytes_remaining;
  logic [u8sd_pkg::LEN_W-1:0] bytes_remaining_next;
  logic [u8sd_pkg::CP_W-1:0]  partial_value;
  logic [u8sd_pkg::CP_W-1:0]  partial_value_next;

  logic [u8sd_pkg::LEN_W-1:0] lead;
  logic                       s_emit;
  logic                       s_open;
  u8sd_pkg::result_t          s_res;
  logic [u8sd_pkg::CP_W-1:0]  s_pv;
  logic [u8sd_pkg::LEN_W-1:0] s_rem;
  logic [u8sd_pkg::CP_W-1:0]  cont_value;
  logic                       is_cont;
  u8sd_pkg::push_t            p;

  always_comb begin
    lead   = u8sd_pkg::lead_ones(held_byte);
    s_pv   = {{(u8sd_pkg::CP_W - u8sd_pkg::BYTE_W){1'b0}},
              held_byte & (u8sd_pkg::FULL_MASK >> lead)};
    s_rem  = lead - u8sd_pkg::LEN_W'(1);
    s_open = (lead > u8sd_pkg::LEN_W'(1));
    s_emit = !s_open;
    s_res.last = 1'b0;
    if (lead == '0) begin
      s_res.code_point = {{(u8sd_pkg::CP_W - u8sd_pkg::BYTE_W){1'b0}}, held_byte};
      s_res.error      = 1'b0;
    end else begin
      s_res.code_point = u8sd_pkg::ALL_ONES;
      s_res.error      = 1'b1;
    end

    is_cont    = ((held_byte & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_TAG);
    cont_value = {partial_value[u8sd_pkg::CP_W-u8sd_pkg::PAYLOAD_W-1:0],
                  held_byte[u8sd_pkg::PAYLOAD_W-1:0]};

    p                    = '0;
    bytes_remaining_next = bytes_remaining;
    partial_value_next   = partial_value;

    if (!decode_enable) begin
      p.v0                 = 1'b1;
      p.r0.code_point      = {{(u8sd_pkg::CP_W - u8sd_pkg::BYTE_W){1'b0}}, held_byte};
      bytes_remaining_next = '0;
      partial_value_next   = '0;
    end else if (bytes_remaining != '0) begin
      if (!is_cont) begin
        p.v0                 = 1'b1;
        p.r0.code_point      = u8sd_pkg::ALL_ONES;
        p.r0.error           = 1'b1;
        p.v1                 = s_emit;
        p.r1                 = s_res;
        bytes_remaining_next = s_open ? s_rem : '0;
        partial_value_next   = s_open ? s_pv : '0;
      end else begin
        bytes_remaining_next = bytes_remaining - u8sd_pkg::LEN_W'(1);
        partial_value_next   = cont_value;
        if (bytes_remaining == u8sd_pkg::LEN_W'(1)) begin
          partial_value_next = '0;
          p.v0               = 1'b1;
          if (cont_value <= u8sd_pkg::OVERLONG_MAX) begin
            p.r0.code_point = u8sd_pkg::ALL_ONES;
            p.r0.error      = 1'b1;
          end else begin
            p.r0.code_point = cont_value;
          end
        end
      end
    end else begin
      p.v0 = s_emit;
      p.r0 = s_res;
      if (s_open) begin
        bytes_remaining_next = s_rem;
        partial_value_next   = s_pv;
      end
    end

    p.r0.last = !p.v1;
    p.r1.last = 1'b1;
    p.v0      = p.v0 && fire;
    p.v1      = p.v1 && fire;
    push      = p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      partial_value   <= '0;
    end else if (fire) begin
      bytes_remaining <= bytes_remaining_next;
      partial_value   <= partial_value_next;
    end
  end

endmodule
`default_nettype wire

[sv/u8sd_out_fifo.sv]
// Small result queue that takes up to two results per cycle and gives one per transaction.
`default_nettype none
module u8sd_out_fifo (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire u8sd_pkg::push_t push,
  output logic             room,
  u8sd_result_if.source    results
);

  u8sd_pkg::result_t           entries [u8sd_pkg::FIFO_DEPTH];
  logic [u8sd_pkg::PTR_W-1:0]  wptr;
  logic [u8sd_pkg::PTR_W-1:0]  rptr;
  logic [u8sd_pkg::CNT_W-1:0]  count;
  logic [u8sd_pkg::PTR_W-1:0]  wptr_second;
  logic [u8sd_pkg::CNT_W-1:0]  push_cnt;
  logic                        pop;
  u8sd_pkg::result_t           head;

  assign wptr_second = wptr + u8sd_pkg::PTR_W'(1);
  assign push_cnt    = u8sd_pkg::CNT_W'(push.v0) + u8sd_pkg::CNT_W'(push.v1);
  assign pop         = results.valid && results.ready;
  assign room        = (count <= u8sd_pkg::ROOM_MAX);
  assign head        = entries[rptr];

  assign results.valid      = (count != '0);
  assign results.code_point = head.code_point;
  assign results.error      = head.error;
  assign results.last       = head.last;

  always_ff @(posedge clk) begin
    if (push.v0) begin
      entries[wptr] <= push.r0;
    end
    if (push.v1) begin
      entries[wptr_second] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + push_cnt[u8sd_pkg::PTR_W-1:0];
      count <= count + push_cnt - u8sd_pkg::CNT_W'(pop);
      if (pop) begin
        rptr <= rptr + u8sd_pkg::PTR_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[sv/utf8_stream_decoder_unit.sv]
// Top level of the UTF-8 stream decoder: configuration register, input stage, decoder, result queue.
// An accepted byte waits in the input stage register until the queue has room; its results then enter the queue.
// Throughput: one byte per cycle while the result channel keeps up; the input stalls whenever
// fewer than two of the four result queue entries are free.
// Reset: rst is synchronous; it empties the queue and input stage, closes any open sequence,
// and sets decode_enable to 1.
`default_nettype none
module utf8_stream_decoder_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  u8sd_byte_if.sink       bytes,
  u8sd_result_if.source   results
);

  logic                          decode_enable;
  logic                          room;
  logic                          fire;
  logic [u8sd_pkg::BYTE_W-1:0]   held_byte;
  u8sd_pkg::push_t               push;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_enable <= 1'b1;
    end else if (cfg_we) begin
      decode_enable <= cfg_wdata;
    end
  end

  u8sd_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes),
    .room      (room),
    .fire      (fire),
    .held_byte (held_byte)
  );

  u8sd_decoder u_decoder (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .held_byte     (held_byte),
    .decode_enable (decode_enable),
    .push          (push)
  );

  u8sd_out_fifo u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .results (results)
  );

endmodule
`default_nettype wire
